// ===== rtl/core/tcpq_pkg.sv =====
// Shared types, constants and helpers for the two-class priority queue.
// No dependencies; imported by two_class_priority_queue, tcpq_ptrs and tb_top.
package tcpq_pkg;

  localparam int Capacity = 16;
  localparam int PtrW     = (Capacity > 1) ? $clog2(Capacity) : 1;
  localparam int CntW     = $clog2(Capacity + 1);
  localparam int ValW     = 32;
  localparam int OccW     = 5;

  typedef logic [PtrW-1:0] ptr_t;
  typedef logic [CntW-1:0] cnt_t;
  typedef logic [ValW-1:0] val_t;

  typedef enum logic [1:0] {
    REQ_INSERT  = 2'd0,
    REQ_REMOVE  = 2'd1,
    REQ_PROMOTE = 2'd2,
    REQ_NOP     = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_FULL      = 2'd2,
    ST_NO_NORMAL = 2'd3
  } status_e;

  // pointer update requests for one item
  typedef struct packed {
    logic push_u;
    logic pop_u;
    logic push_n;
    logic pop_n;
  } ptr_upd_t;

  // ring pointers and fill counts of both classes
  typedef struct packed {
    ptr_t u_head;
    ptr_t u_tail;
    cnt_t u_cnt;
    ptr_t n_head;
    ptr_t n_tail;
    cnt_t n_cnt;
  } ptr_state_t;

  function automatic ptr_t ring_next(input ptr_t p);
    ptr_t r;
    if (p == PtrW'(Capacity - 1)) begin
      r = '0;
    end else begin
      r = p + PtrW'(1);
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/two_class_priority_queue.sv =====
// Top level of the two-class strict-priority queue.
// Depends on tcpq_pkg, tcpq_ram and tcpq_ptrs.
//
// Usage:
//   Requests enter on the in channel (in_valid_i / in_stall_o) with req_type_i,
//   value_in_i and is_urgent_i. Every accepted item yields exactly one result
//   item on the out channel (out_valid_o / out_stall_i): value_out_o, status_o
//   and occupancy_o (total entries held after the request).
//   Insert, failing requests and the unused code finish in the accept cycle:
//   the result is registered and shows up in the cycle after acceptance; the
//   next item can be taken in the following cycle, so these run at 1 item/cycle
//   while the receiver takes results. Remove and promote read an entry from a
//   ring memory with a registered read port: the accept cycle issues the read,
//   and the read cycle (ST_READ) captures the data (and, for promote, writes it
//   to the urgent tail). The result is registered at the end of the read cycle,
//   and the input is stalled during the read cycle.
//   The output register frees the input side: an item is accepted while a
//   result is being taken. If the receiver holds out_stall_i high, the result
//   holds and the input stalls once the output register is occupied.
//   Reset (rst_ni low, async) empties both classes; memory contents are not
//   cleared since only written entries are ever read.
module two_class_priority_queue (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [1:0]             req_type_i,
  input  logic signed [31:0]     value_in_i,
  input  logic                   is_urgent_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic signed [31:0]     value_out_o,
  output logic [1:0]             status_o,
  output logic [4:0]             occupancy_o
);
  import tcpq_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_READ = 2'b10
  } fsm_e;

  fsm_e       state_q, state_d;
  ptr_upd_t   upd;
  ptr_state_t pst;

  // pending read context, captured at accept
  logic       rd_urg_q;
  logic       promo_q;
  ptr_t       wtail_q;

  // output register
  logic       out_valid_q, out_valid_d;
  val_t       value_q;
  status_e    status_q;
  logic [OccW-1:0] occ_q;

  // ring memory ports
  logic u_we, u_re, n_we, n_re;
  ptr_t u_waddr;
  val_t u_wdata, u_rdata, n_rdata;

  logic    in_acc;
  logic    out_take;
  req_e    req;
  cnt_t    total;
  logic    full;
  logic    rd_need;
  logic    rd_urg;
  logic    ins_ok;
  status_e status_imm;
  val_t    rd_val;

  assign req      = req_e'(req_type_i);
  assign total    = CntW'(pst.u_cnt + pst.n_cnt);
  assign full     = (total >= CntW'(Capacity));
  assign out_take = out_valid_q && !out_stall_i;

  // only idle with a free (or draining) output register takes an item
  assign in_stall_o = (state_q != ST_IDLE) || (out_valid_q && out_stall_i);
  assign in_acc     = in_valid_i && !in_stall_o;

  // request decode against the current ring state
  always_comb begin
    upd        = '0;
    rd_need    = 1'b0;
    rd_urg     = 1'b0;
    ins_ok     = 1'b0;
    status_imm = ST_OK;
    unique case (req)
      REQ_INSERT: begin
        if (full) begin
          status_imm = ST_FULL;
        end else begin
          ins_ok     = 1'b1;
          upd.push_u = is_urgent_i;
          upd.push_n = !is_urgent_i;
        end
      end
      REQ_REMOVE: begin
        if (pst.u_cnt != '0) begin
          upd.pop_u = 1'b1;
          rd_need   = 1'b1;
          rd_urg    = 1'b1;
        end else if (pst.n_cnt != '0) begin
          upd.pop_n = 1'b1;
          rd_need   = 1'b1;
        end else begin
          status_imm = ST_EMPTY;
        end
      end
      REQ_PROMOTE: begin
        if (pst.n_cnt == '0) begin
          status_imm = ST_NO_NORMAL;
        end else begin
          // oldest normal leaves, urgent tail slot is reserved now
          upd.pop_n  = 1'b1;
          upd.push_u = 1'b1;
          rd_need    = 1'b1;
        end
      end
      REQ_NOP: begin
        status_imm = ST_OK;
      end
      default: begin
        status_imm = ST_OK;
      end
    endcase
    if (!in_acc) begin
      upd = '0;
    end
  end

  tcpq_ptrs u_ptrs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .upd_i  (upd),
    .st_o   (pst)
  );

  // Urgent ring: written on urgent insert, or by the promote write-back in the
  // read cycle. These never coincide since no item is taken during ST_READ.
  always_comb begin
    u_we    = 1'b0;
    u_waddr = pst.u_tail;
    u_wdata = value_in_i;
    if (state_q == ST_READ && promo_q) begin
      u_we    = 1'b1;
      u_waddr = wtail_q;
      u_wdata = n_rdata;
    end else if (in_acc && ins_ok && is_urgent_i) begin
      u_we = 1'b1;
    end
  end

  assign n_we = in_acc && ins_ok && !is_urgent_i;
  assign u_re = in_acc && upd.pop_u;
  assign n_re = in_acc && upd.pop_n;

  tcpq_ram #(.Depth(Capacity), .Width(ValW)) u_urgent_ram (
    .clk_i   (clk_i),
    .we_i    (u_we),
    .waddr_i (u_waddr),
    .wdata_i (u_wdata),
    .re_i    (u_re),
    .raddr_i (pst.u_head),
    .rdata_o (u_rdata)
  );

  tcpq_ram #(.Depth(Capacity), .Width(ValW)) u_normal_ram (
    .clk_i   (clk_i),
    .we_i    (n_we),
    .waddr_i (pst.n_tail),
    .wdata_i (value_in_i),
    .re_i    (n_re),
    .raddr_i (pst.n_head),
    .rdata_o (n_rdata)
  );

  // FSM
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && rd_need) state_d = ST_READ;
      end
      ST_READ: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // read context; payload only, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      rd_urg_q <= rd_urg;
      promo_q  <= (req == REQ_PROMOTE);
      wtail_q  <= pst.u_tail;
    end
  end

  assign rd_val = rd_urg_q ? u_rdata : n_rdata;

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (state_q == ST_READ || (in_acc && !rd_need)) begin
      out_valid_d = 1'b1;
    end else if (out_take) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_READ) begin
      // counts were already updated at accept
      value_q  <= promo_q ? '0 : rd_val;
      status_q <= ST_OK;
      occ_q    <= OccW'(total);
    end else if (in_acc && !rd_need) begin
      value_q  <= '0;
      status_q <= status_imm;
      occ_q    <= OccW'(total + CntW'(ins_ok));
    end
  end

  assign out_valid_o = out_valid_q;
  assign value_out_o = value_q;
  assign status_o    = status_q;
  assign occupancy_o = occ_q;

`ifndef SYNTHESIS
  // the read cycle always finds the output register free
  a_read_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_READ |-> !out_valid_q)
    else $error("output register busy in read cycle");

  // a memory-reading item always moves to the read cycle
  a_read_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && rd_need |=> state_q == ST_READ)
    else $error("read cycle missing after remove/promote");

  // total holdings never exceed the capacity
  a_total_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total <= CntW'(Capacity))
    else $error("queue holds more than capacity");

  // a result is produced by the read cycle
  a_read_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_READ |=> out_valid_q)
    else $error("read cycle produced no result");
`endif

endmodule

// ===== rtl/core/tcpq_ram.sv =====
// Generic single-write, single-read synchronous RAM with a registered read port.
// No dependencies.
module tcpq_ram #(
  parameter int Depth = 16,
  parameter int Width = 32,
  parameter int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/tcpq_ptrs.sv =====
// Head/tail ring pointers and fill counts of the urgent and normal rings.
// Depends on tcpq_pkg.
module tcpq_ptrs (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  tcpq_pkg::ptr_upd_t   upd_i,
  output tcpq_pkg::ptr_state_t st_o
);
  import tcpq_pkg::*;

  ptr_state_t st_q, st_d;

  always_comb begin
    st_d = st_q;
    if (upd_i.push_u) st_d.u_tail = ring_next(st_q.u_tail);
    if (upd_i.pop_u)  st_d.u_head = ring_next(st_q.u_head);
    if (upd_i.push_n) st_d.n_tail = ring_next(st_q.n_tail);
    if (upd_i.pop_n)  st_d.n_head = ring_next(st_q.n_head);
    st_d.u_cnt = st_q.u_cnt + CntW'(upd_i.push_u) - CntW'(upd_i.pop_u);
    st_d.n_cnt = st_q.n_cnt + CntW'(upd_i.push_n) - CntW'(upd_i.pop_n);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else begin
      st_q <= st_d;
    end
  end

  assign st_o = st_q;

endmodule

// ===== tb/tb_top.sv =====
// Self-checking bench for the two-class priority queue: directed corner cases,
// then phased random traffic. Checks every result against an in-bench model.
// Depends on tcpq_pkg and the two_class_priority_queue RTL.
module tb_top;
  import tcpq_pkg::*;

  typedef struct packed {
    val_t              value;
    status_e           status;
    logic [OccW-1:0]   occ;
  } answer_t;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_stall_o;
  logic [1:0]        req_type_i;
  logic signed [31:0] value_in_i;
  logic              is_urgent_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic signed [31:0] value_out_o;
  logic [1:0]        status_o;
  logic [4:0]        occupancy_o;

  // model of the two rings, oldest entry at the front
  val_t    urgent_q[$];
  val_t    normal_q[$];
  answer_t awaited[$];
  answer_t want;

  int  errors;
  int  checked;
  int  status_seen[4];
  int  peak_occ;
  bit  calm;

  two_class_priority_queue dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .req_type_i  (req_type_i),
    .value_in_i  (value_in_i),
    .is_urgent_i (is_urgent_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .value_out_o (value_out_o),
    .status_o    (status_o),
    .occupancy_o (occupancy_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] exp);
    $display("MISMATCH at %0t: %s, got %h, expected %h", $time, what, got, exp);
    errors++;
  endtask

  // Work out the answer to one accepted request and queue it.
  task automatic apply_request(input req_e req, input val_t v, input logic urg);
    answer_t a;
    a.value  = '0;
    a.status = ST_OK;
    case (req)
      REQ_INSERT: begin
        if (urgent_q.size() + normal_q.size() >= Capacity) begin
          a.status = ST_FULL;
        end else if (urg) begin
          urgent_q.push_back(v);
        end else begin
          normal_q.push_back(v);
        end
      end
      REQ_REMOVE: begin
        if (urgent_q.size() != 0) begin
          a.value = urgent_q.pop_front();
        end else if (normal_q.size() != 0) begin
          a.value = normal_q.pop_front();
        end else begin
          a.status = ST_EMPTY;
        end
      end
      REQ_PROMOTE: begin
        // legal even when full: the entry only changes class
        if (normal_q.size() == 0) begin
          a.status = ST_NO_NORMAL;
        end else begin
          urgent_q.push_back(normal_q.pop_front());
        end
      end
      default: begin
      end
    endcase
    a.occ = OccW'(urgent_q.size() + normal_q.size());
    if (urgent_q.size() + normal_q.size() > peak_occ) begin
      peak_occ = urgent_q.size() + normal_q.size();
    end
    status_seen[a.status]++;
    awaited.push_back(a);
  endtask

  // Drive one item at the falling edge and hold it until taken.
  task automatic send_request(input req_e req, input val_t v, input logic urg);
    @(negedge clk_i);
    in_valid_i  = 1'b1;
    req_type_i  = req;
    value_in_i  = v;
    is_urgent_i = urg;
    @(posedge clk_i);
    while (in_stall_o) begin
      @(posedge clk_i);
    end
    apply_request(req, v, urg);
  endtask

  task automatic input_gap(input int n);
    @(negedge clk_i);
    in_valid_i = 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  function automatic val_t rand_value();
    val_t v;
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 3))
          0: v = 32'h8000_0000;
          1: v = 32'h7fff_ffff;
          2: v = 32'h0000_0000;
          default: v = 32'hffff_ffff;
        endcase
      end
      default: v = $urandom;
    endcase
    return v;
  endfunction

  task automatic test_empty_requests();
    send_request(REQ_REMOVE, 32'hdead_beef, 1'b1);
    send_request(REQ_PROMOTE, 32'h1234_5678, 1'b0);
    send_request(REQ_NOP, 32'hffff_ffff, 1'b1);
  endtask

  // urgent entries leave first, each class in arrival order
  task automatic test_class_order();
    send_request(REQ_INSERT, 32'h7fff_ffff, 1'b0);
    send_request(REQ_INSERT, 32'h0000_0000, 1'b0);
    send_request(REQ_INSERT, 32'h8000_0000, 1'b1);
    send_request(REQ_INSERT, 32'hffff_ffff, 1'b1);
    send_request(REQ_REMOVE, 32'h5555_5555, 1'b0);
    send_request(REQ_NOP, 32'haaaa_aaaa, 1'b0);
    send_request(REQ_REMOVE, 32'h0, 1'b1);
    send_request(REQ_REMOVE, 32'h0, 1'b0);
    send_request(REQ_REMOVE, 32'h0, 1'b0);
    send_request(REQ_REMOVE, 32'h0, 1'b0);
  endtask

  // promoted entry lands behind existing urgent ones; failing promote with
  // urgent entries still present
  task automatic test_promotion();
    send_request(REQ_INSERT, 32'h0000_0005, 1'b1);
    send_request(REQ_INSERT, 32'h0000_0001, 1'b0);
    send_request(REQ_INSERT, 32'h0000_0002, 1'b0);
    send_request(REQ_PROMOTE, 32'hffff_ffff, 1'b1);
    send_request(REQ_PROMOTE, 32'h0, 1'b0);
    send_request(REQ_PROMOTE, 32'h0, 1'b0);
    send_request(REQ_REMOVE, 32'h0, 1'b0);
    send_request(REQ_REMOVE, 32'h0, 1'b0);
    send_request(REQ_REMOVE, 32'h0, 1'b0);
  endtask

  // Phases that lean toward filling, draining or a mix, so full and empty
  // are both reached many times.
  task automatic test_random_traffic(input int n, input bit gaps);
    int   done;
    int   span;
    int   mode;
    int   pick;
    int   ins_w;
    int   rem_w;
    int   pro_w;
    bit   gapped;
    req_e req;
    done = 0;
    while (done < n) begin
      mode   = $urandom_range(0, 2);
      span   = $urandom_range(16, 64);
      gapped = gaps && ($urandom_range(0, 3) != 0);
      case (mode)
        0: begin
          ins_w = 70; rem_w = 15; pro_w = 12;
        end
        1: begin
          ins_w = 20; rem_w = 62; pro_w = 15;
        end
        default: begin
          ins_w = 40; rem_w = 35; pro_w = 22;
        end
      endcase
      for (int k = 0; k < span && done < n; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < ins_w) begin
          req = REQ_INSERT;
        end else if (pick < ins_w + rem_w) begin
          req = REQ_REMOVE;
        end else if (pick < ins_w + rem_w + pro_w) begin
          req = REQ_PROMOTE;
        end else begin
          req = REQ_NOP;
        end
        send_request(req, rand_value(), 1'($urandom_range(0, 1)));
        done++;
        if (gapped && $urandom_range(0, 4) == 0) begin
          input_gap($urandom_range(1, 10));
        end
      end
    end
  endtask

  // receiver back-pressure in bursts; quiet once calm is set
  initial begin
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (calm || $urandom_range(0, 2) != 0) begin
        out_stall_i = 1'b0;
      end else begin
        out_stall_i = 1'b1;
        repeat ($urandom_range(0, 9)) @(negedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      checked++;
      if (awaited.size() == 0) begin
        report_mismatch("result with nothing pending", value_out_o, 32'h0);
      end else begin
        want = awaited.pop_front();
        if (value_out_o !== want.value) begin
          report_mismatch("value_out", value_out_o, want.value);
        end
        if (status_o !== want.status) begin
          report_mismatch("status", 32'(status_o), 32'(want.status));
        end
        if (occupancy_o !== want.occ) begin
          report_mismatch("occupancy", 32'(occupancy_o), 32'(want.occ));
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("Timeout with %0d results still pending", awaited.size());
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    errors      = 0;
    checked     = 0;
    peak_occ    = 0;
    calm        = 1'b0;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    req_type_i  = REQ_NOP;
    value_in_i  = '0;
    is_urgent_i = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_empty_requests();
    test_class_order();
    test_promotion();
    test_random_traffic(1680, 1'b1);
    // final stretch at full rate on both sides
    calm = 1'b1;
    test_random_traffic(150, 1'b0);

    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (awaited.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (10) @(posedge clk_i);

    $display("Checked %0d results: %0d ok, %0d removes on empty, %0d full drops,",
             checked, status_seen[ST_OK], status_seen[ST_EMPTY], status_seen[ST_FULL]);
    $display("%0d promotes with no normal entry, peak occupancy %0d",
             status_seen[ST_NO_NORMAL], peak_occ);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
